// ===== rtl/phm_pkg.sv =====
package phm_pkg;

	localparam int FRAME_BITS = 16;
	localparam int LEVEL_W    = 16;
	localparam int VEL_W      = 18;
	localparam int CFG_IDX_W  = 3;

	// serial multiplier: 17-bit operands, one multiplier bit per cycle
	localparam int MUL_W     = 17;
	localparam int MUL_CNT_W = $clog2(MUL_W + 1);

	localparam logic [MUL_W-1:0]   ONE_Q16 = MUL_W'(65536);
	localparam logic [LEVEL_W-1:0] MAX_Q16 = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DECAY_PER_FRAME = 3'd0,
		REG_SILENCE_LEVEL   = 3'd1,
		REG_LIT_ALPHA_BASE  = 3'd2,
		REG_LIT_ALPHA_SPAN  = 3'd3,
		REG_RESTING_ALPHA   = 3'd4,
		REG_GLOW_BASE       = 3'd5,
		REG_GLOW_SPAN       = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		OP_TRIGGER = 1'b0,
		OP_ADVANCE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POW_ISSUE,
		ST_POW_WAIT,
		ST_LVL_ISSUE,
		ST_LVL_WAIT,
		ST_EVAL_ISSUE,
		ST_EVAL_WAIT,
		ST_WRITE
	} state_t;

endpackage

// ===== rtl/phm_if.sv =====
interface phm_cmd_if;
	logic                             valid;
	logic                             ready;
	logic                             op;
	logic signed [phm_pkg::VEL_W-1:0] velocity;
	logic [phm_pkg::FRAME_BITS-1:0]   frames;

	modport source (output valid, op, velocity, frames, input ready);
	modport sink   (input valid, op, velocity, frames, output ready);
endinterface

interface phm_res_if;
	logic                          valid;
	logic                          ready;
	logic [phm_pkg::LEVEL_W-1:0]   level_out;
	logic                          lit;
	logic [phm_pkg::LEVEL_W-1:0]   led_alpha;
	logic [phm_pkg::LEVEL_W-1:0]   glow_radius;

	modport source (output valid, level_out, lit, led_alpha, glow_radius, input ready);
	modport sink   (input valid, level_out, lit, led_alpha, glow_radius, output ready);
endinterface

interface phm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [phm_pkg::CFG_IDX_W-1:0]   index;
	logic [phm_pkg::LEVEL_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/phm_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, Q1.16 round half up.
module phm_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        done,
	input  logic [phm_pkg::MUL_W-1:0]   a,
	input  logic [phm_pkg::MUL_W-1:0]   b,
	output logic [phm_pkg::MUL_W-1:0]   result
);

	logic [phm_pkg::MUL_W-1:0]     a_q;
	logic [phm_pkg::MUL_W-1:0]     b_q;
	logic [phm_pkg::MUL_W-1:0]     hi_q;
	logic [phm_pkg::MUL_W-1:0]     lo_q;
	logic [phm_pkg::MUL_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [phm_pkg::MUL_W:0]       sum;
	logic [phm_pkg::MUL_W:0]       rounded;

	assign sum = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : '0);

	// product is {hi, lo}; rounding adds bit 15 to bits 33:16
	assign rounded = {hi_q, lo_q[phm_pkg::MUL_W-1]}
		+ {{phm_pkg::MUL_W{1'b0}}, lo_q[phm_pkg::MUL_W-2]};
	assign result  = rounded[phm_pkg::MUL_W-1:0];
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= phm_pkg::MUL_CNT_W'(phm_pkg::MUL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == phm_pkg::MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			b_q  <= b_q >> 1;
			hi_q <= sum[phm_pkg::MUL_W:1];
			lo_q <= {sum[0], lo_q[phm_pkg::MUL_W-1:1]};
		end
	end

endmodule

// ===== rtl/peak_hold_level_decay_meter.sv =====
// Sequence: a trigger, or an advance that changes nothing, goes straight to the alpha
// and glow multiplies; an advance that decays first raises the decay factor to the
// frame count by squaring, one frame bit per phase, then scales the level. Each
// multiply phase runs 17 bit-serial steps after its issue state.
// Throughput: one item at a time, the next beat taken the cycle after the result is
// registered, even while the previous result waits. Reset clears the level and loads
// every register default.
module peak_hold_level_decay_meter (
	input  logic             clk,
	input  logic             arst_n,
	phm_cmd_if.sink          cmd,
	phm_res_if.source        res,
	phm_cfg_if.sink          cfg
);

	localparam int W  = phm_pkg::LEVEL_W;
	localparam int MW = phm_pkg::MUL_W;

	phm_pkg::state_t state_q, state_d;

	// configuration registers
	logic [W-1:0] decay_q, silence_q, alpha_base_q, alpha_span_q;
	logic [W-1:0] resting_q, glow_base_q, glow_span_q;

	// meter state and exponentiation working registers
	logic [W-1:0]                    level_q;
	logic [MW-1:0]                   acc_q;
	logic [W-1:0]                    base_q;
	logic [phm_pkg::FRAME_BITS-1:0]  fr_q;

	// result register
	logic         res_valid_q;
	logic [W-1:0] res_level_q, res_alpha_q, res_glow_q;
	logic         res_lit_q;

	logic          m0_start, m0_done, m1_start, m1_done;
	logic [MW-1:0] m0_a, m0_b, m1_a, m1_b, m0_res, m1_res;

	logic          cmd_fire;
	logic          res_free;
	logic [W-1:0]  vel_clamped;
	logic [W-1:0]  lvl_decayed;
	logic [MW:0]   alpha_sum, glow_sum;
	logic [W-1:0]  alpha_val, glow_val;
	logic          lit;

	assign cmd.ready = (state_q == phm_pkg::ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;
	assign res_free  = !res_valid_q || res.ready;

	assign res.valid       = res_valid_q;
	assign res.level_out   = res_level_q;
	assign res.lit         = res_lit_q;
	assign res.led_alpha   = res_alpha_q;
	assign res.glow_radius = res_glow_q;

	// clamp velocity to 0..1: negative drops to 0, one or more holds at full scale
	always_comb begin
		if (cmd.velocity[phm_pkg::VEL_W-1])
			vel_clamped = '0;
		else if (cmd.velocity[W])
			vel_clamped = phm_pkg::MAX_Q16;
		else
			vel_clamped = cmd.velocity[W-1:0];
	end

	// decayed level: saturate, then snap to zero at or below silence
	always_comb begin
		if (m0_res[MW-1])
			lvl_decayed = phm_pkg::MAX_Q16;
		else
			lvl_decayed = m0_res[W-1:0];
		if (lvl_decayed <= silence_q)
			lvl_decayed = '0;
	end

	// alpha and glow from the evaluation multiplies, saturated to 16 bits
	assign lit       = (level_q != '0);
	assign alpha_sum = {2'b00, alpha_base_q} + {1'b0, m0_res};
	assign glow_sum  = {2'b00, glow_base_q} + {1'b0, m1_res};
	assign alpha_val = (alpha_sum[MW:W] != '0) ? phm_pkg::MAX_Q16 : alpha_sum[W-1:0];
	assign glow_val  = (glow_sum[MW:W] != '0) ? phm_pkg::MAX_Q16 : glow_sum[W-1:0];

	// operand steering: squaring step, level scaling, then alpha and glow
	always_comb begin
		m0_a = {1'b0, level_q};
		m0_b = acc_q;
		m1_a = {1'b0, level_q};
		m1_b = {1'b0, glow_span_q};
		m0_start = 1'b0;
		m1_start = 1'b0;
		case (state_q)
			phm_pkg::ST_POW_ISSUE: begin
				m0_a = acc_q;
				m0_b = {1'b0, base_q};
				m1_a = {1'b0, base_q};
				m1_b = {1'b0, base_q};
				m0_start = (fr_q != '0);
				m1_start = (fr_q != '0);
			end
			phm_pkg::ST_LVL_ISSUE: begin
				m0_start = 1'b1;
			end
			phm_pkg::ST_EVAL_ISSUE: begin
				m0_b = {1'b0, alpha_span_q};
				m0_start = 1'b1;
				m1_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	phm_mul u_mul0 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (m0_start),
		.done   (m0_done),
		.a      (m0_a),
		.b      (m0_b),
		.result (m0_res)
	);

	phm_mul u_mul1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (m1_start),
		.done   (m1_done),
		.a      (m1_a),
		.b      (m1_b),
		.result (m1_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= phm_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			phm_pkg::ST_IDLE: begin
				if (cmd_fire) begin
					if (cmd.op == phm_pkg::OP_ADVANCE && cmd.frames != '0 && level_q != '0)
						state_d = phm_pkg::ST_POW_ISSUE;
					else
						state_d = phm_pkg::ST_EVAL_ISSUE;
				end
			end
			phm_pkg::ST_POW_ISSUE: begin
				// out of frame bits: scale the level by the finished power
				if (fr_q == '0)
					state_d = phm_pkg::ST_LVL_ISSUE;
				else
					state_d = phm_pkg::ST_POW_WAIT;
			end
			phm_pkg::ST_POW_WAIT: begin
				if (m0_done && m1_done)
					state_d = phm_pkg::ST_POW_ISSUE;
			end
			phm_pkg::ST_LVL_ISSUE:  state_d = phm_pkg::ST_LVL_WAIT;
			phm_pkg::ST_LVL_WAIT: begin
				if (m0_done)
					state_d = phm_pkg::ST_EVAL_ISSUE;
			end
			phm_pkg::ST_EVAL_ISSUE: state_d = phm_pkg::ST_EVAL_WAIT;
			phm_pkg::ST_EVAL_WAIT: begin
				if (m0_done && m1_done)
					state_d = phm_pkg::ST_WRITE;
			end
			phm_pkg::ST_WRITE: begin
				// hold until the previous result beat has gone
				if (res_free)
					state_d = phm_pkg::ST_IDLE;
			end
			default: state_d = phm_pkg::ST_IDLE;
		endcase
	end

	// configuration writes and the level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q      <= W'(58982);
			silence_q    <= W'(66);
			alpha_base_q <= W'(16384);
			alpha_span_q <= W'(49151);
			resting_q    <= W'(14418);
			glow_base_q  <= W'(512);
			glow_span_q  <= W'(2048);
			level_q      <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (phm_pkg::cfg_reg_t'(cfg.index))
					phm_pkg::REG_DECAY_PER_FRAME: decay_q      <= cfg.data;
					phm_pkg::REG_SILENCE_LEVEL:   silence_q    <= cfg.data;
					phm_pkg::REG_LIT_ALPHA_BASE:  alpha_base_q <= cfg.data;
					phm_pkg::REG_LIT_ALPHA_SPAN:  alpha_span_q <= cfg.data;
					phm_pkg::REG_RESTING_ALPHA:   resting_q    <= cfg.data;
					phm_pkg::REG_GLOW_BASE:       glow_base_q  <= cfg.data;
					phm_pkg::REG_GLOW_SPAN:       glow_span_q  <= cfg.data;
					default: begin
					end
				endcase
			end
			// trigger: peak hold on the clamped velocity
			if (cmd_fire && cmd.op == phm_pkg::OP_TRIGGER && vel_clamped > level_q)
				level_q <= vel_clamped;
			if (state_q == phm_pkg::ST_LVL_WAIT && m0_done)
				level_q <= lvl_decayed;
		end
	end

	// exponentiation by squaring, frame bits scanned from the LSB
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			acc_q  <= phm_pkg::ONE_Q16;
			base_q <= decay_q;
			fr_q   <= cmd.frames;
		end else if (state_q == phm_pkg::ST_POW_WAIT && m0_done && m1_done) begin
			if (fr_q[0])
				acc_q <= m0_res;
			base_q <= m1_res[W-1:0];
			fr_q   <= fr_q >> 1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (state_q == phm_pkg::ST_WRITE && res_free)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == phm_pkg::ST_WRITE && res_free) begin
			res_level_q <= level_q;
			res_lit_q   <= lit;
			res_alpha_q <= lit ? alpha_val : resting_q;
			res_glow_q  <= lit ? glow_val : '0;
		end
	end

endmodule

// ===== sim/peak_hold_meter_checker.sv =====
module peak_hold_meter_checker
	import phm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	phm_cmd_if   cmd,
	phm_res_if   res,
	phm_cfg_if   cfg,
	output int   outstanding,
	output int   fail_cnt,
	output int   reading_cnt,
	output int   snap_cnt,
	output int   sat_cnt
);

	localparam logic [LEVEL_W-1:0] DEF_DECAY      = 16'd58982;
	localparam logic [LEVEL_W-1:0] DEF_SILENCE    = 16'd66;
	localparam logic [LEVEL_W-1:0] DEF_ALPHA_BASE = 16'd16384;
	localparam logic [LEVEL_W-1:0] DEF_ALPHA_SPAN = 16'd49151;
	localparam logic [LEVEL_W-1:0] DEF_RESTING    = 16'd14418;
	localparam logic [LEVEL_W-1:0] DEF_GLOW_BASE  = 16'd512;
	localparam logic [LEVEL_W-1:0] DEF_GLOW_SPAN  = 16'd2048;
	localparam logic [31:0]        UNITY_Q16      = 32'd65536;
	localparam logic [31:0]        TOP_Q16        = 32'd65535;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               lit;
		logic [LEVEL_W-1:0] alpha;
		logic [LEVEL_W-1:0] glow;
	} meter_reading_t;

	logic [LEVEL_W-1:0] decay_q, silence_q, alpha_base_q, alpha_span_q;
	logic [LEVEL_W-1:0] resting_q, glow_base_q, glow_span_q;
	logic [LEVEL_W-1:0] held_level;
	meter_reading_t     reading_q[$];

	// exact product, rounded half up back to Q16.16
	function automatic logic [31:0] mul_q16(logic [31:0] a, logic [31:0] b);
		logic [63:0] p;
		p = {32'd0, a} * {32'd0, b} + 64'd32768;
		return p[47:16];
	endfunction

	function automatic logic [31:0] clip16(logic [31:0] v);
		return (v > TOP_Q16) ? TOP_Q16 : v;
	endfunction

	// decay factor to the n-th power, scanning frame bits from the bottom
	function automatic logic [31:0] decay_gain(logic [FRAME_BITS-1:0] n);
		logic [31:0] acc;
		logic [31:0] base;
		acc  = UNITY_Q16;
		base = {16'd0, decay_q};
		for (int i = 0; i < FRAME_BITS; i++) begin
			if (n[i])
				acc = mul_q16(acc, base);
			base = mul_q16(base, base);
		end
		return acc;
	endfunction

	// advance the held level by one beat and form the reading it reports
	function automatic meter_reading_t next_reading(op_t op, logic signed [VEL_W-1:0] vel,
			logic [FRAME_BITS-1:0] frames);
		meter_reading_t r;
		logic [31:0]    lvl;
		logic [31:0]    hit;
		logic [31:0]    a;
		logic [31:0]    g;
		lvl = {16'd0, held_level};
		if (op == OP_TRIGGER) begin
			if (vel[VEL_W-1])
				hit = 32'd0;
			else if (vel[VEL_W-2:LEVEL_W] != '0)
				hit = TOP_Q16;
			else
				hit = {16'd0, vel[LEVEL_W-1:0]};
			if (hit > lvl)
				lvl = hit;
		end else if (frames != '0 && lvl != 32'd0) begin
			lvl = clip16(mul_q16(lvl, decay_gain(frames)));
			if (lvl <= {16'd0, silence_q}) begin
				lvl = 32'd0;
				snap_cnt++;
			end
		end
		held_level = lvl[LEVEL_W-1:0];
		r.level    = held_level;
		r.lit      = (lvl != 32'd0);
		if (r.lit) begin
			a = {16'd0, alpha_base_q} + mul_q16(lvl, {16'd0, alpha_span_q});
			g = {16'd0, glow_base_q} + mul_q16(lvl, {16'd0, glow_span_q});
			if (a > TOP_Q16 || g > TOP_Q16)
				sat_cnt++;
			r.alpha = clip16(a);
			r.glow  = clip16(g);
		end else begin
			r.alpha = resting_q;
			r.glow  = '0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		meter_reading_t want;
		meter_reading_t got;
		if (!arst_n) begin
			decay_q      = DEF_DECAY;
			silence_q    = DEF_SILENCE;
			alpha_base_q = DEF_ALPHA_BASE;
			alpha_span_q = DEF_ALPHA_SPAN;
			resting_q    = DEF_RESTING;
			glow_base_q  = DEF_GLOW_BASE;
			glow_span_q  = DEF_GLOW_SPAN;
			held_level   = '0;
			reading_q.delete();
			fail_cnt     = 0;
			reading_cnt  = 0;
			snap_cnt     = 0;
			sat_cnt      = 0;
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_DECAY_PER_FRAME: decay_q      = cfg.data;
					REG_SILENCE_LEVEL:   silence_q    = cfg.data;
					REG_LIT_ALPHA_BASE:  alpha_base_q = cfg.data;
					REG_LIT_ALPHA_SPAN:  alpha_span_q = cfg.data;
					REG_RESTING_ALPHA:   resting_q    = cfg.data;
					REG_GLOW_BASE:       glow_base_q  = cfg.data;
					REG_GLOW_SPAN:       glow_span_q  = cfg.data;
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				got = '{res.level_out, res.lit, res.led_alpha, res.glow_radius};
				if (reading_q.size() == 0) begin
					$error("result beat with no reading pending");
					fail_cnt++;
				end else begin
					want = reading_q.pop_front();
					reading_cnt++;
					if (got.level !== want.level) begin
						$error("level_out: expected %0d, got %0d", want.level, got.level);
						fail_cnt++;
					end
					if (got.lit !== want.lit) begin
						$error("lit: expected %0d, got %0d", want.lit, got.lit);
						fail_cnt++;
					end
					if (got.alpha !== want.alpha) begin
						$error("led_alpha: expected %0d, got %0d", want.alpha, got.alpha);
						fail_cnt++;
					end
					if (got.glow !== want.glow) begin
						$error("glow_radius: expected %0d, got %0d", want.glow, got.glow);
						fail_cnt++;
					end
				end
			end
			if (cmd.valid && cmd.ready)
				reading_q.push_back(next_reading(op_t'(cmd.op), cmd.velocity, cmd.frames));
			outstanding <= reading_q.size();
		end
	end

endmodule

// ===== sim/peak_hold_level_decay_meter_tb.sv =====
module peak_hold_level_decay_meter_tb
	import phm_pkg::*;
;

	// random part: eight register settings, each followed by a run of beats
	localparam int N_SETTINGS        = 8;
	localparam int ITEMS_PER_SETTING = 235;
	localparam int HOLD_SETTING      = 3;
	localparam int HOLD_AT_ITEM      = 40;
	localparam int LONG_HOLD_CYCLES  = 400;
	// quiet tail watched for stray result beats after the final drain
	localparam int DRAIN_CYCLES      = 400;
	localparam int CYCLE_LIMIT       = 4_000_000;

	// index past the register list; the block must ignore it
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

	typedef struct {
		logic [LEVEL_W-1:0] decay;
		logic [LEVEL_W-1:0] silence;
		logic [LEVEL_W-1:0] alpha_base;
		logic [LEVEL_W-1:0] alpha_span;
		logic [LEVEL_W-1:0] resting;
		logic [LEVEL_W-1:0] glow_base;
		logic [LEVEL_W-1:0] glow_span;
	} meter_setting_t;

	logic clk = 1'b0;
	logic arst_n;

	// idle controls: src_idle lives in the stimulus process only, the
	// others cross into the result sink and are moved with nonblocking writes
	bit src_idle;
	bit sink_idle;
	bit hold_req;

	int outstanding;
	int fail_cnt;
	int reading_cnt;
	int snap_cnt;
	int sat_cnt;
	int setting_cnt;

	phm_cmd_if cmd_bus ();
	phm_res_if res_bus ();
	phm_cfg_if cfg_bus ();

	always #5 clk = ~clk;

	peak_hold_level_decay_meter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus),
		.cfg    (cfg_bus)
	);

	peak_hold_meter_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_bus),
		.res         (res_bus),
		.cfg         (cfg_bus),
		.outstanding (outstanding),
		.fail_cnt    (fail_cnt),
		.reading_cnt (reading_cnt),
		.snap_cnt    (snap_cnt),
		.sat_cnt     (sat_cnt)
	);

	// Offer one command beat and hold it until the block takes it. An idle
	// burst, when drawn, drops valid first so the gap lands wherever the
	// block happens to be in its multiply sequence.
	task automatic send_item(op_t op, logic signed [VEL_W-1:0] vel,
			logic [FRAME_BITS-1:0] frames);
		if (src_idle && $urandom_range(0, 4) == 0) begin
			cmd_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		cmd_bus.valid    <= 1'b1;
		cmd_bus.op       <= op;
		cmd_bus.velocity <= vel;
		cmd_bus.frames   <= frames;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
	endtask

	// Draw a command: triggers get a spread of in-range, negative and
	// over-unity velocities; advances mostly get short frame counts so the
	// level lives long enough to be decayed again, with some full-width counts.
	task automatic random_item();
		op_t                   op;
		logic signed [VEL_W-1:0] vel;
		logic [FRAME_BITS-1:0] frames;
		op = ($urandom_range(0, 99) < 45) ? OP_TRIGGER : OP_ADVANCE;
		case ($urandom_range(0, 7))
			0: vel = {1'b1, 17'($urandom)};
			1: vel = {2'b01, 16'($urandom)};
			2: begin
				case ($urandom_range(0, 4))
					0: vel = '0;
					1: vel = 18'sd1;
					2: vel = 18'sd65535;
					3: vel = 18'sd65536;
					default: vel = -18'sd1;
				endcase
			end
			default: vel = {2'b00, 16'($urandom)};
		endcase
		case ($urandom_range(0, 15))
			0: frames = '0;
			1: frames = FRAME_BITS'($urandom);
			2: frames = '1;
			3, 4: frames = FRAME_BITS'($urandom_range(1, 255));
			default: frames = FRAME_BITS'($urandom_range(1, 40));
		endcase
		send_item(op, vel, frames);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
	endtask

	// Load a whole setting back to back, plus a stray write to the spare
	// index, then drop valid.
	task automatic load_setting(meter_setting_t s);
		write_reg(REG_DECAY_PER_FRAME, s.decay);
		write_reg(REG_SILENCE_LEVEL, s.silence);
		write_reg(REG_LIT_ALPHA_BASE, s.alpha_base);
		write_reg(REG_LIT_ALPHA_SPAN, s.alpha_span);
		write_reg(REG_RESTING_ALPHA, s.resting);
		write_reg(REG_GLOW_BASE, s.glow_base);
		write_reg(REG_GLOW_SPAN, s.glow_span);
		write_reg(CFG_IDX_SPARE, LEVEL_W'($urandom));
		cfg_bus.valid <= 1'b0;
	endtask

	// Extremes first (all ones, all zeros), then the reset values written
	// back explicitly, then random settings with a slow decay so the level
	// survives several advances.
	function automatic meter_setting_t pick_setting(int k);
		meter_setting_t s;
		case (k)
			0: s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
			1: s = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
			2: s = '{16'd58982, 16'd66, 16'd16384, 16'd49151, 16'd14418, 16'd512, 16'd2048};
			default: begin
				s.decay      = LEVEL_W'($urandom_range(16'hC000, 16'hFFFF));
				s.silence    = LEVEL_W'($urandom_range(0, 2000));
				s.alpha_base = LEVEL_W'($urandom);
				s.alpha_span = LEVEL_W'($urandom);
				s.resting    = LEVEL_W'($urandom);
				s.glow_base  = LEVEL_W'($urandom);
				s.glow_span  = LEVEL_W'($urandom);
			end
		endcase
		return s;
	endfunction

	// Result sink: ready in random stall bursts while sink_idle is set; once,
	// on request, hold off for a long stretch so the block backs up and
	// stalls its command input.
	initial begin : result_sink
		bit hold_done;
		hold_done = 1'b0;
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				res_bus.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				res_bus.ready <= 1'b1;
			end else if (sink_idle && $urandom_range(0, 5) == 0) begin
				res_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				res_bus.ready <= 1'b1;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d readings still pending", cycle_cnt,
			outstanding);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		meter_setting_t s;
		// drive every input to a known value before the first edge
		cmd_bus.valid    <= 1'b0;
		cmd_bus.op       <= OP_TRIGGER;
		cmd_bus.velocity <= '0;
		cmd_bus.frames   <= '0;
		cfg_bus.valid    <= 1'b0;
		cfg_bus.index    <= REG_DECAY_PER_FRAME;
		cfg_bus.data     <= '0;
		hold_req         <= 1'b0;
		sink_idle        <= 1'b1;
		src_idle          = 1'b1;
		setting_cnt       = 0;
		arst_n           <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats under the reset registers: advance on an empty meter,
		// negative and most-negative velocities, peak hold against a smaller
		// hit, zero frames, velocities at and past unity, a full-width frame
		// count, and decays that end at or just under the silence level.
		send_item(OP_ADVANCE, VEL_W'($urandom), 16'd7);
		send_item(OP_TRIGGER, -18'sd1, FRAME_BITS'($urandom));
		send_item(OP_TRIGGER, -18'sd131072, FRAME_BITS'($urandom));
		send_item(OP_TRIGGER, 18'sd0, FRAME_BITS'($urandom));
		send_item(OP_TRIGGER, 18'sd1000, FRAME_BITS'($urandom));
		send_item(OP_TRIGGER, 18'sd500, FRAME_BITS'($urandom));
		send_item(OP_ADVANCE, VEL_W'($urandom), 16'd0);
		send_item(OP_ADVANCE, VEL_W'($urandom), 16'd1);
		send_item(OP_TRIGGER, 18'sd65535, FRAME_BITS'($urandom));
		send_item(OP_TRIGGER, 18'sd65536, FRAME_BITS'($urandom));
		send_item(OP_TRIGGER, 18'sd131071, FRAME_BITS'($urandom));
		send_item(OP_ADVANCE, VEL_W'($urandom), 16'd3);
		send_item(OP_ADVANCE, VEL_W'($urandom), 16'hFFFF);
		send_item(OP_TRIGGER, 18'sd32768, FRAME_BITS'($urandom));
		send_item(OP_ADVANCE, VEL_W'($urandom), 16'h8000);
		send_item(OP_TRIGGER, 18'sd20000, FRAME_BITS'($urandom));
		send_item(OP_ADVANCE, VEL_W'($urandom), 16'h5555);
		send_item(OP_TRIGGER, 18'sd300, FRAME_BITS'($urandom));
		send_item(OP_ADVANCE, VEL_W'($urandom), 16'd1);
		send_item(OP_ADVANCE, VEL_W'($urandom), 16'd30);
		send_item(OP_TRIGGER, 18'sd70, FRAME_BITS'($urandom));
		send_item(OP_ADVANCE, VEL_W'($urandom), 16'd1);

		for (int k = 0; k < N_SETTINGS; k++) begin
			// drop valid and wait for the clock so the count includes the last
			// beat, then drain before touching the registers
			cmd_bus.valid <= 1'b0;
			@(posedge clk);
			while (outstanding != 0) @(posedge clk);
			s = pick_setting(k);
			load_setting(s);
			setting_cnt++;

			// no idling at all in the last two settings
			if (k >= N_SETTINGS - 2) begin
				src_idle   = 1'b0;
				sink_idle <= 1'b0;
			end else if (k > 0) begin
				src_idle   = ($urandom_range(0, 3) != 0);
				sink_idle <= ($urandom_range(0, 3) != 0);
			end

			for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
				random_item();
				// keep offering beats while the sink holds off
				if (k == HOLD_SETTING && n == HOLD_AT_ITEM)
					hold_req <= 1'b1;
			end
		end

		// drain, then watch the tail for stray result beats
		cmd_bus.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d readings checked under reset values and %0d loaded settings",
			reading_cnt, setting_cnt);
		$display("run: %0d decays fell to silence, %0d readings saturated alpha or glow",
			snap_cnt, sat_cnt);
		if (fail_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
